FILE: src/dllr_pkg.sv
// Package: shared types, constants and colour functions for the line renderer.
package dllr_pkg;

   localparam int LIST_LINES_DEF    = 307;
   localparam int BLANK_LINES_DEF   = 19;
   localparam int VISIBLE_LINES_DEF = 288;
   localparam logic [15:0] WALK_START = 16'o270;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      OP_FRAME = 2'd0,
      OP_DESC  = 2'd1,
      OP_OCTET = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_DESC   = 2'd0,
      KIND_DOT    = 2'd1,
      KIND_REPORT = 2'd2
   } kind_type;

   localparam logic [1:0] MODE_RGB  = 2'd0;
   localparam logic [1:0] MODE_GRB  = 2'd1;
   localparam logic [1:0] MODE_GREY = 2'd2;

   // One queued job for the back end
   typedef struct packed {
      kind_type    kind;
      logic [15:0] fetch_address;
      logic        fetch_extended;
      logic [15:0] line_address;
      logic        line_visible;
      logic [6:0]  octets_in_line;
      logic [23:0] plane_bytes;
      logic [31:0] palette;
      logic [2:0]  brightness;
      logic [3:0]  cursor_colour;
      logic        cursor_on;
      logic        cursor_single;
      logic [2:0]  cursor_dot;
      logic [1:0]  scale;
      logic [8:0]  count;
   } job_type;

   function automatic logic [7:0] channel_level(logic on, logic bright, logic dim);
      logic [7:0] v;
      if (!on) v = 8'h00;
      else if (bright) v = dim ? 8'hDF : 8'hFF;
      else v = dim ? 8'h60 : 8'h80;
      return v;
   endfunction

   function automatic logic [23:0] rom_colour(logic [1:0] mode, logic [6:0] index);
      logic [7:0]  r, g, b;
      logic [23:0] c;
      logic [2:0]  lv;
      lv = index[2:0];
      r = channel_level(index[2], index[3], index[6]);
      g = channel_level(index[1], index[3], index[5]);
      b = channel_level(index[0], index[3], index[4]);
      if (mode == MODE_GREY) begin
         c = (lv == 3'd7) ? 24'hFFFFFF : 24'(24'h242424 * lv);
      end else if (mode == MODE_GRB) begin
         c = {g, r, b};
      end else begin
         c = {r, g, b};
      end
      return c;
   endfunction

endpackage

FILE: src/dllr_front.sv
// Front end: accepts items, walks the descriptor list and builds back-end jobs.
module dllr_front #(
   parameter int LIST_LINES    = dllr_pkg::LIST_LINES_DEF,
   parameter int BLANK_LINES   = dllr_pkg::BLANK_LINES_DEF,
   parameter int VISIBLE_LINES = dllr_pkg::VISIBLE_LINES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        opcode,
   input  logic [8:0]        line_number,
   input  logic [15:0]       ext_word_low,
   input  logic [15:0]       ext_word_high,
   input  logic [15:0]       dot_address,
   input  logic [15:0]       link_word,
   input  logic [23:0]       plane_bytes,
   output logic              job_valid,
   input  logic              job_ready,
   output dllr_pkg::job_type job
);
   logic [15:0] next_address_ff, next_address_in;
   logic next_extended_ff, next_extended_in, next_is_palette_ff, next_is_palette_in;
   logic cursor_active_ff, cursor_active_in;
   logic [31:0] palette_ff, palette_in;
   logic [2:0] bright_ff, bright_in;
   logic [3:0] cur_colour_ff, cur_colour_in;
   logic cur_single_ff, cur_single_in;
   logic [6:0] cur_octet_ff, cur_octet_in;
   logic [2:0] cur_dot_ff, cur_dot_in;
   logic [1:0] scale_ff, scale_in;
   logic [6:0] octet_pos_ff, octet_pos_in;
   logic [8:0] count_ff, count_in;
   logic take, emits;
   logic [1:0] sc;
   logic [15:0] shifted;
   dllr_pkg::opcode_type op;

   assign op = dllr_pkg::opcode_type'(opcode);
   assign in_ready = job_ready;
   assign take = in_valid && in_ready;

   // Update walk state and form the job
   always_comb begin
      next_address_in = next_address_ff;
      next_extended_in = next_extended_ff;
      next_is_palette_in = next_is_palette_ff;
      cursor_active_in = cursor_active_ff;
      palette_in = palette_ff;
      bright_in = bright_ff;
      cur_colour_in = cur_colour_ff;
      cur_single_in = cur_single_ff;
      cur_octet_in = cur_octet_ff;
      cur_dot_in = cur_dot_ff;
      scale_in = scale_ff;
      octet_pos_in = octet_pos_ff;
      count_in = count_ff;
      emits = 1'b0;
      sc = scale_ff;
      shifted = '0;
      job = '0;
      job.palette = palette_ff;
      job.brightness = bright_ff;
      job.cursor_colour = cur_colour_ff;
      job.cursor_single = cur_single_ff;
      job.cursor_dot = cur_dot_ff;
      job.scale = scale_ff;
      job.plane_bytes = plane_bytes;
      unique case (op)
         dllr_pkg::OP_FRAME: begin
            emits = 1'b1;
            job.kind = dllr_pkg::KIND_REPORT;
            job.count = count_ff;
            next_address_in = dllr_pkg::WALK_START;
            next_extended_in = 1'b0;
            next_is_palette_in = 1'b0;
            cursor_active_in = 1'b0;
            count_in = '0;
         end
         dllr_pkg::OP_DESC: begin
            if (32'(line_number) < 32'(LIST_LINES)) begin
               emits = 1'b1;
               if (next_extended_ff) begin
                  if (next_is_palette_ff) begin
                     palette_in = {ext_word_high, ext_word_low};
                  end else begin
                     sc = ext_word_high[5:4];
                     scale_in = sc;
                     bright_in = 3'd7 - ext_word_high[2:0];
                     cur_colour_in = ext_word_low[3:0];
                     cur_single_in = ext_word_low[4];
                     cur_dot_in = ext_word_low[7:5];
                     shifted = {8'd0, ext_word_low[15:8]} >> sc;
                     cur_octet_in = shifted[6:0];
                  end
               end
               next_extended_in = link_word[1];
               if (link_word[1]) begin
                  next_address_in = {link_word[15:3], 3'd0};
                  next_is_palette_in = link_word[2];
               end else begin
                  next_address_in = {link_word[15:2], 2'd0};
               end
               if (link_word[0]) cursor_active_in = ~cursor_active_ff;
               if (count_ff != 9'h1FF) count_in = count_ff + 9'd1;
               octet_pos_in = '0;
               job.kind = dllr_pkg::KIND_DESC;
               job.fetch_address = next_address_in;
               job.fetch_extended = next_extended_in;
               job.line_address = dot_address;
               job.line_visible = (32'(line_number) >= 32'(BLANK_LINES)) &&
                  (32'(line_number) - 32'(BLANK_LINES) < 32'(VISIBLE_LINES));
               job.octets_in_line = 7'(7'd80 >> sc);
            end
         end
         dllr_pkg::OP_OCTET: begin
            emits = 1'b1;
            job.kind = dllr_pkg::KIND_DOT;
            job.cursor_on = cursor_active_ff && (octet_pos_ff == cur_octet_ff);
            if (octet_pos_ff != 7'h7F) octet_pos_in = octet_pos_ff + 7'd1;
         end
         default: ;
      endcase
   end

   assign job_valid = take && emits;

   // Commit state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         next_address_ff <= dllr_pkg::WALK_START;
         next_extended_ff <= 1'b0;
         next_is_palette_ff <= 1'b0;
         cursor_active_ff <= 1'b0;
         palette_ff <= '0;
         bright_ff <= '0;
         cur_colour_ff <= '0;
         cur_single_ff <= 1'b0;
         cur_octet_ff <= '0;
         cur_dot_ff <= '0;
         scale_ff <= '0;
         octet_pos_ff <= '0;
         count_ff <= '0;
      end else if (take) begin
         next_address_ff <= next_address_in;
         next_extended_ff <= next_extended_in;
         next_is_palette_ff <= next_is_palette_in;
         cursor_active_ff <= cursor_active_in;
         palette_ff <= palette_in;
         bright_ff <= bright_in;
         cur_colour_ff <= cur_colour_in;
         cur_single_ff <= cur_single_in;
         cur_octet_ff <= cur_octet_in;
         cur_dot_ff <= cur_dot_in;
         scale_ff <= scale_in;
         octet_pos_ff <= octet_pos_in;
         count_ff <= count_in;
      end
   end
endmodule

FILE: src/dllr_queue.sv
// Job queue: small FIFO between front end and back end.
module dllr_queue #(
   parameter int DEPTH = dllr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  dllr_pkg::job_type wr_job,
   output logic              rd_valid,
   input  logic              rd_ready,
   output dllr_pkg::job_type rd_job
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   dllr_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic do_wr, do_rd;

   assign wr_ready = (32'(cnt_ff) < DEPTH);
   assign rd_valid = (cnt_ff != '0);
   assign rd_job = mem_ff[rp_ff];
   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_valid && rd_ready;

   // Store entries
   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_job;
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_wr) wp_ff <= (32'(wp_ff) == DEPTH - 1) ? '0 : wp_ff + 1'b1;
         if (do_rd) rp_ff <= (32'(rp_ff) == DEPTH - 1) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_wr) - (AW+1)'(do_rd);
      end
   end
endmodule

FILE: src/dllr_back.sv
// Back end: emits replies, reports and eight colour-mapped dots per octet.
module dllr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        color_mode,
   input  logic              job_valid,
   output logic              job_ready,
   input  dllr_pkg::job_type job,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [1:0]        result_kind,
   output logic [15:0]       fetch_address,
   output logic              fetch_extended,
   output logic [15:0]       line_address,
   output logic              line_visible,
   output logic [6:0]        octets_in_line,
   output logic [23:0]       dot_color,
   output logic [3:0]        dot_repeat,
   output logic              last_dot,
   output logic [8:0]        descriptors_done
);
   logic [2:0] dot_ff, dot_in;
   logic valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [15:0] fa_ff, la_ff;
   logic fe_ff, lv_ff, last_ff;
   logic [6:0] oil_ff;
   logic [23:0] col_ff, col;
   logic [3:0] rep_ff;
   logic [8:0] done_ff;
   logic load, is_dot, finish;
   logic [2:0] c;
   logic [3:0] yrgb;

   assign is_dot = job.kind == dllr_pkg::KIND_DOT;
   assign load = job_valid && (!valid_ff || out_ready);
   assign finish = !is_dot || dot_ff == 3'd7;
   assign job_ready = load && finish;

   // Look up the current dot
   always_comb begin
      c = {job.plane_bytes[5'd16 + 5'(dot_ff)], job.plane_bytes[5'd8 + 5'(dot_ff)],
           job.plane_bytes[5'(dot_ff)]};
      yrgb = job.palette[{c, 2'b00} +: 4];
      col = dllr_pkg::rom_colour(color_mode, {job.brightness, yrgb});
      if (job.cursor_on && (!job.cursor_single || dot_ff == job.cursor_dot))
         col = dllr_pkg::rom_colour(color_mode, {3'd0, job.cursor_colour});
   end

   assign valid_in = load ? 1'b1 : (valid_ff && !out_ready);
   assign dot_in = (load && is_dot) ? dot_ff + 3'd1 : dot_ff;

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dot_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         dot_ff <= dot_in;
      end
   end

   // Load output register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= job.kind;
         fa_ff <= is_dot ? '0 : job.fetch_address;
         fe_ff <= job.fetch_extended;
         la_ff <= job.line_address;
         lv_ff <= job.line_visible;
         oil_ff <= job.octets_in_line;
         col_ff <= is_dot ? col : '0;
         rep_ff <= is_dot ? 4'(4'd1 << job.scale) : '0;
         last_ff <= is_dot && dot_ff == 3'd7;
         done_ff <= job.count;
      end
   end

   assign out_valid = valid_ff;
   assign result_kind = kind_ff;
   assign fetch_address = fa_ff;
   assign fetch_extended = fe_ff;
   assign line_address = la_ff;
   assign line_visible = lv_ff;
   assign octets_in_line = oil_ff;
   assign dot_color = col_ff;
   assign dot_repeat = rep_ff;
   assign last_dot = last_ff;
   assign descriptors_done = done_ff;
endmodule

FILE: src/display_list_line_renderer.sv
// Top level: display list line renderer.
// Usage:
//  - req_ channel carries one item per transaction: frame start, line descriptor
//    or dot octet, selected by req_tuser (opcode).
//  - rsp_ channel returns descriptor replies, frame reports and dots; rsp_tuser
//    holds the result kind, rsp_tlast marks the eighth dot of an octet.
//  - csr_ write sets the colour mode; write only while the block is idle.
// Path: when idle, an accepted item is written into the job queue and then loaded
// into the back-end output register, where its first result is presented.
// Throughput: a descriptor or frame item gives one result; an octet gives eight
// dots, one dot per cycle while rsp_tready is high, set by the dot sequencer.
// The front end takes items back to back while the four-entry job queue has room.
// Reset: synchronous; the walk restarts at octal 270, all setup is cleared,
// the queue and output register empty.
// Stall: when rsp_tready is low the output register holds, the back end waits,
// the queue fills and then req_tready drops.
module display_list_line_renderer #(
   parameter int LIST_LINES    = dllr_pkg::LIST_LINES_DEF,
   parameter int BLANK_LINES   = dllr_pkg::BLANK_LINES_DEF,
   parameter int VISIBLE_LINES = dllr_pkg::VISIBLE_LINES_DEF,
   parameter int QUEUE_DEPTH   = dllr_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // line_number[8:0], ext_word_low[24:9], ext_word_high[40:25], dot_address[56:41],
   // link_word[72:57], plane0_byte[80:73], plane1_byte[88:81], plane2_byte[96:89]
   input  logic [103:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fetch_address[15:0], fetch_extended[16], line_address[32:17],
   // line_visible[33], octets_in_line[40:34], dot_color[64:41],
   // dot_repeat[68:65], descriptors_done[77:69]
   output logic [79:0]  rsp_tdata,
   // result_kind[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);
   logic [1:0] mode_ff;
   logic fq_valid, fq_ready, bq_valid, bq_ready;
   dllr_pkg::job_type fjob, bjob;
   logic [15:0] fa, la;
   logic fe, lv, ld;
   logic [6:0] oil;
   logic [23:0] dc;
   logic [3:0] dr;
   logic [8:0] dd;

   // Hold the colour mode register
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= dllr_pkg::MODE_RGB;
      else if (csr_wr_en) mode_ff <= csr_wr_data;
   end

   dllr_front #(.LIST_LINES(LIST_LINES), .BLANK_LINES(BLANK_LINES),
                .VISIBLE_LINES(VISIBLE_LINES)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .opcode(req_tuser), .line_number(req_tdata[8:0]),
      .ext_word_low(req_tdata[24:9]), .ext_word_high(req_tdata[40:25]),
      .dot_address(req_tdata[56:41]), .link_word(req_tdata[72:57]),
      .plane_bytes({req_tdata[96:89], req_tdata[88:81], req_tdata[80:73]}),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fjob)
   );

   dllr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fjob),
      .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_job(bjob)
   );

   dllr_back u_back (
      .clock, .reset, .color_mode(mode_ff),
      .job_valid(bq_valid), .job_ready(bq_ready), .job(bjob),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .result_kind(rsp_tuser), .fetch_address(fa), .fetch_extended(fe),
      .line_address(la), .line_visible(lv), .octets_in_line(oil),
      .dot_color(dc), .dot_repeat(dr), .last_dot(ld), .descriptors_done(dd)
   );

   logic is_desc, is_rep;
   assign is_desc = rsp_tuser == dllr_pkg::KIND_DESC;
   assign is_rep = rsp_tuser == dllr_pkg::KIND_REPORT;
   assign rsp_tdata = {2'b00, is_rep ? dd : 9'd0, dr, dc, is_desc ? oil : 7'd0,
                       is_desc & lv, is_desc ? la : 16'd0, is_desc & fe, fa};
   assign rsp_tlast = ld;
endmodule

FILE: src/dllr_checker.sv
// Checker: port-level properties of the line renderer, bound to the top level.
module dllr_assertions (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled transaction changed");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == dllr_pkg::KIND_DESC || rsp_tuser == dllr_pkg::KIND_DOT ||
                      rsp_tuser == dllr_pkg::KIND_REPORT))
      else $error("bad result kind");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == dllr_pkg::KIND_DOT)
      else $error("tlast on non-dot");
   a_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dllr_pkg::KIND_DOT |-> $onehot(rsp_tdata[68:65]))
      else $error("dot repeat not a power of two");
endmodule

bind display_list_line_renderer dllr_assertions u_assertions (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
);
